@@ design/ips_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the include preamble scanner.
// Used by ips_front, ips_queue, ips_back and the top level.
package ips_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_NL = 8'h0A;

	typedef enum logic [1:0] {
		MODE_SCAN,
		MODE_COMMENT,
		MODE_DONE
	} mode_t;

	typedef enum logic [1:0] {
		CLOSE_NONE,
		CLOSE_AT_END,
		CLOSE_BAD
	} close_t;

	// One classified byte as it travels from front to back.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       nl;
		logic       ws;
		logic [1:0] span_len;
		logic       bad_lead;
	} item_t;

	// Per-line scan state.
	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] last;
		logic [1:0] kept;
		logic [1:0] pend;
		logic [1:0] left;
		logic       span_open;
		logic [3:0] inc;
		close_t     close;
	} line_t;

endpackage

@@ design/include_preamble_scanner.sv @@
`timescale 1ns / 1ps
// Include preamble scanner, top level.
// Source channel: one text byte per beat (char_byte), end_of_text marks the final
// byte of a text; newline bytes split lines.
// Result channel: one beat per text, carrying preamble_lines (one-based number of
// the last #include line before the first ordinary line) and utf8_error.
// Throughput: one source beat per cycle while no result beat is held by res_stall,
// set by the line scanner in the back end; the two-entry queue lets the front keep
// taking bytes while the back waits on the result register.
// The end_of_text beat passes through the queue; the result beat is registered when the back takes it.
// Reset: queue empty, scanner back at the start of a text, no result pending.
// Result stall: the result beat holds; the back stops taking beats while a result
// beat waits, and src_stall rises when the queue fills.
// Depends on ips_pkg, ips_front, ips_queue and ips_back.
module include_preamble_scanner #(
	parameter int LINE_COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] preamble_lines,
	output logic        utf8_error
);
	import ips_pkg::*;

	item_t push_item;
	item_t head_item;
	logic  push;
	logic  pop;
	logic  full;
	logic  head_valid;

	ips_front u_front (
		.src_valid  (src_valid),
		.char_byte  (char_byte),
		.end_of_text(end_of_text),
		.queue_full (full),
		.src_stall  (src_stall),
		.push       (push),
		.item       (push_item)
	);

	ips_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	ips_back #(
		.LINE_COUNT_BITS(LINE_COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.preamble_lines(preamble_lines),
		.utf8_error    (utf8_error)
	);

endmodule

@@ design/ips_front.sv @@
`timescale 1ns / 1ps
// Front end: takes source beats, classifies each byte and pushes it to the queue.
// Depends on ips_pkg.
module ips_front (
	input  logic          src_valid,
	input  logic [7:0]    char_byte,
	input  logic          end_of_text,
	input  logic          queue_full,
	output logic          src_stall,
	output logic          push,
	output ips_pkg::item_t item
);
	import ips_pkg::*;

	logic is_ws;
	logic is_hi;

	assign is_ws = (char_byte == 8'h20) || ((char_byte >= 8'h09) && (char_byte <= 8'h0D));
	assign is_hi = char_byte[7];

	assign src_stall = queue_full;
	assign push      = src_valid && !queue_full;

	always_comb begin
		item.ch       = char_byte;
		item.last     = end_of_text;
		item.nl       = (char_byte == CH_NL);
		item.ws       = is_ws;
		item.span_len = 2'd0;
		item.bad_lead = 1'b0;
		if (is_hi) begin
			if ((char_byte & 8'hE0) == 8'hC0) begin
				item.span_len = 2'd1;
			end else if ((char_byte & 8'hF0) == 8'hE0) begin
				item.span_len = 2'd2;
			end else if ((char_byte & 8'hF8) == 8'hF0) begin
				item.span_len = 2'd3;
			end else begin
				item.bad_lead = 1'b1;
			end
		end
	end

endmodule

@@ design/ips_queue.sv @@
`timescale 1ns / 1ps
// Short queue between front and back, built from registers.
// Depends on ips_pkg.
module ips_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ips_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output ips_pkg::item_t head_item
);
	import ips_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

@@ design/ips_back.sv @@
`timescale 1ns / 1ps
// Back end: line scanner state machine and the registered result beat.
// Depends on ips_pkg.
module ips_back #(
	parameter int LINE_COUNT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  ips_pkg::item_t head_item,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_stall,
	output logic [15:0]    preamble_lines,
	output logic           utf8_error
);
	import ips_pkg::*;

	localparam int         LW       = LINE_COUNT_BITS;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [3:0] INC_DONE = 4'd7;
	localparam logic [3:0] INC_FAIL = 4'd15;

	function automatic line_t line_clear();
		line_t l;
		l.first     = '0;
		l.second    = '0;
		l.last      = '0;
		l.kept      = '0;
		l.pend      = '0;
		l.left      = '0;
		l.span_open = 1'b0;
		l.inc       = '0;
		l.close     = CLOSE_NONE;
		return l;
	endfunction

	function automatic logic [7:0] inc_char(logic [3:0] p);
		logic [7:0] r;
		case (p)
			4'd0:    r = 8'h69;
			4'd1:    r = 8'h6E;
			4'd2:    r = 8'h63;
			4'd3:    r = 8'h6C;
			4'd4:    r = 8'h75;
			4'd5:    r = 8'h64;
			4'd6:    r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] inc_step(logic [3:0] p, logic [7:0] c, logic c_ws);
		logic [3:0] r;
		r = p;
		if (p == INC_DONE || p == INC_FAIL) begin
			r = p;
		end else if (p == 4'd0 && c_ws) begin
			r = p;
		end else begin
			r = (c == inc_char(p)) ? p + 4'd1 : INC_FAIL;
		end
		return r;
	endfunction

	function automatic line_t commit(line_t l_in, mode_t m, logic [7:0] c);
		line_t      l;
		logic [2:0] sum;
		l = l_in;
		if (l.close != CLOSE_NONE) begin
			l.close = CLOSE_BAD;
		end else if (c == CH_SLASH && l.pend == 2'd0 && l.kept != 2'd0 && l.last == CH_STAR
				&& (m == MODE_COMMENT || l.kept == 2'd3)) begin
			l.close = CLOSE_AT_END;
		end
		if (l.kept != 2'd0 && l.first == CH_HASH) begin
			l.inc = inc_step(l.inc, c, 1'b0);
		end
		if (l.kept == 2'd0) begin
			l.first = c;
		end else if (l.kept == 2'd1) begin
			l.second = (l.pend != 2'd0) ? CH_SPACE : c;
		end
		sum    = {1'b0, l.kept} + {1'b0, l.pend} + 3'd1;
		l.kept = (sum > 3'd3) ? 2'd3 : sum[1:0];
		l.pend = 2'd0;
		l.last = c;
		return l;
	endfunction

	mode_t           mode_q;
	line_t           line_q;
	logic [LW-1:0]   idx_q;
	logic [LW-1:0]   cnt_q;
	logic            err_q;
	logic            res_valid_q;
	logic [15:0]     lines_q;
	logic            uerr_q;

	mode_t           mode_d;
	line_t           line_d;
	logic [LW-1:0]   idx_d;
	logic [LW-1:0]   cnt_d;
	logic            err_d;
	logic            emit;
	logic            emit_err;
	logic [15:0]     emit_lines;
	logic [31:0]     cnt_wide;

	assign pop = head_valid && (!res_valid_q || !res_stall);

	always_comb begin
		line_t         ln;
		mode_t         md;
		mode_t         nxt;
		logic          er;
		logic [LW-1:0] li;
		logic [LW-1:0] pc;
		logic [7:0]    c;
		logic          do_commit;
		ln        = line_q;
		md        = mode_q;
		er        = err_q;
		li        = idx_q;
		pc        = cnt_q;
		c         = '0;
		do_commit = 1'b0;
		nxt       = md;
		if (md != MODE_DONE && !head_item.nl) begin
			if (ln.left != 2'd0) begin
				ln.left = ln.left - 2'd1;
				if (ln.left == 2'd0 && !head_item.ws) begin
					ln.span_open = 1'b0;
				end
				c         = CH_AT;
				do_commit = 1'b1;
			end else if (head_item.ws) begin
				if (ln.kept != 2'd0) begin
					if (ln.pend != 2'd3) begin
						ln.pend = ln.pend + 2'd1;
					end
					if (ln.first == CH_HASH) begin
						ln.inc = inc_step(ln.inc, head_item.ch, 1'b1);
					end
				end
			end else begin
				ln.span_open = 1'b0;
				if (head_item.bad_lead) begin
					er = 1'b1;
					md = MODE_DONE;
				end else if (head_item.span_len != 2'd0) begin
					ln.left      = head_item.span_len;
					ln.span_open = 1'b1;
					c            = CH_AT;
					do_commit    = 1'b1;
				end else begin
					c         = head_item.ch;
					do_commit = 1'b1;
				end
			end
		end
		if (do_commit) begin
			ln = commit(ln, md, c);
		end
		if (md != MODE_DONE && (head_item.nl || head_item.last)) begin
			nxt = md;
			if (ln.left != 2'd0 || ln.span_open) begin
				er  = 1'b1;
				nxt = MODE_DONE;
			end else if (md == MODE_COMMENT) begin
				if (ln.close == CLOSE_AT_END) begin
					nxt = MODE_SCAN;
				end else if (ln.close == CLOSE_BAD) begin
					nxt = MODE_DONE;
				end
			end else if (ln.kept == 2'd0) begin
				nxt = MODE_SCAN;
			end else if (ln.kept == 2'd1 || ln.last == CH_BSL) begin
				nxt = MODE_DONE;
			end else if (ln.first == CH_SLASH && ln.second == CH_SLASH) begin
				nxt = MODE_SCAN;
			end else if (ln.first == CH_SLASH && ln.second == CH_STAR) begin
				if (ln.close == CLOSE_AT_END) begin
					nxt = MODE_SCAN;
				end else if (ln.close == CLOSE_BAD) begin
					nxt = MODE_DONE;
				end else begin
					nxt = MODE_COMMENT;
				end
			end else if (ln.first == CH_HASH && ln.inc == INC_DONE) begin
				pc  = (li != {LW{1'b1}}) ? li + LW'(1) : li;
				nxt = MODE_SCAN;
			end else begin
				nxt = MODE_DONE;
			end
			md = nxt;
			if (li != {LW{1'b1}}) begin
				li = li + LW'(1);
			end
			ln = line_clear();
		end
		emit     = head_item.last;
		emit_err = er;
		cnt_wide = 32'(pc);
		if (er) begin
			emit_lines = '0;
		end else begin
			emit_lines = (cnt_wide > 32'h0000_FFFF) ? 16'hFFFF : cnt_wide[15:0];
		end
		err_d = er;
		if (head_item.last) begin
			md = MODE_SCAN;
			li = '0;
			pc = '0;
			ln = line_clear();
			err_d = 1'b0;
		end
		mode_d = md;
		line_d = ln;
		idx_d  = li;
		cnt_d  = pc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SCAN;
			line_q      <= line_clear();
			idx_q       <= '0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q <= mode_d;
				line_q <= line_d;
				idx_q  <= idx_d;
				cnt_q  <= cnt_d;
				err_q  <= err_d;
			end
			if (pop && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			lines_q <= emit_lines;
			uerr_q  <= emit_err;
		end
	end

	assign res_valid      = res_valid_q;
	assign preamble_lines = lines_q;
	assign utf8_error     = uerr_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && utf8_error) |-> (preamble_lines == 16'd0))
		else $error("error result with nonzero count");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DONE && !pop) |=> (mode_q == MODE_DONE))
		else $error("stopped scan left without a beat");
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.last) |=> (idx_q == '0 && mode_q == MODE_SCAN && !err_q && res_valid))
		else $error("end of text did not restart scan");

endmodule

@@ sim/tb_include_preamble_scanner.sv @@
`timescale 1ns / 1ps
// Self-checking bench for include_preamble_scanner: random and directed texts,
// a bit-exact preamble predictor and a result checker over valid/stall channels.
// Depends on ips_pkg and the include_preamble_scanner RTL.
module tb_include_preamble_scanner;
	import ips_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} beat_t;

	typedef struct {
		logic [15:0] lines;
		logic        err;
	} verdict_t;

	localparam logic [3:0]  WORD_DONE = 4'd7;
	localparam logic [3:0]  WORD_FAIL = 4'd15;
	localparam logic [15:0] LINE_MAX  = 16'hFFFF;
	localparam logic [7:0]  CH_SP     = 8'h20;
	localparam logic [7:0]  CH_HASH   = 8'h23;
	localparam logic [7:0]  CH_SLASH  = 8'h2F;
	localparam logic [7:0]  CH_STAR   = 8'h2A;
	localparam logic [7:0]  CH_BSL    = 8'h5C;
	localparam logic [7:0]  CH_AT     = 8'h40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  char_byte = 8'd0;
	logic        end_of_text = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [15:0] preamble_lines;
	logic        utf8_error;

	beat_t      text_q[$];
	verdict_t   verdict_q[$];
	logic [7:0] txt_buf[$];
	int         beats_made = 0;
	int         src_idle_pct = 0;
	int         res_stall_pct = 0;
	logic       hold_on = 1'b0;
	int         mismatches = 0;

	// predictor state
	mode_t       txt_mode;
	logic [15:0] line_no;
	logic [15:0] incl_line;
	logic [7:0]  head_ch;
	logic [7:0]  next_ch;
	logic [7:0]  tail_ch;
	logic [1:0]  kept_n;
	logic [1:0]  gap_n;
	logic [1:0]  cont_left;
	logic        cont_open;
	logic [3:0]  word_pos;
	close_t      close_st;
	logic        bad_utf8;

	include_preamble_scanner u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.char_byte(char_byte),
		.end_of_text(end_of_text),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.preamble_lines(preamble_lines),
		.utf8_error(utf8_error)
	);

	always #4 clk = ~clk;

	function automatic logic blank_ch(logic [7:0] c);
		return c == CH_SP || (c >= 8'd9 && c <= 8'd13);
	endfunction

	task automatic clear_line_state();
		head_ch = 8'd0;
		next_ch = 8'd0;
		tail_ch = 8'd0;
		kept_n = 2'd0;
		gap_n = 2'd0;
		cont_left = 2'd0;
		cont_open = 1'b0;
		word_pos = 4'd0;
		close_st = CLOSE_NONE;
	endtask

	task automatic restart_text();
		txt_mode = MODE_SCAN;
		line_no = 16'd0;
		incl_line = 16'd0;
		bad_utf8 = 1'b0;
		clear_line_state();
	endtask

	task automatic match_word(logic [7:0] c);
		string kw = "include";
		if (word_pos == WORD_DONE || word_pos == WORD_FAIL)
			return;
		if (word_pos == 4'd0 && blank_ch(c))
			return;
		word_pos = (c == kw[word_pos]) ? word_pos + 4'd1 : WORD_FAIL;
	endtask

	task automatic keep_ch(logic [7:0] c);
		int n;
		if (close_st != CLOSE_NONE) begin
			close_st = CLOSE_BAD;
		end else if (c == CH_SLASH && gap_n == 2'd0 && kept_n >= 2'd1 && tail_ch == CH_STAR
				&& (txt_mode == MODE_COMMENT || kept_n == 2'd3)) begin
			close_st = CLOSE_AT_END;
		end
		if (kept_n >= 2'd1 && head_ch == CH_HASH)
			match_word(c);
		if (kept_n == 2'd0)
			head_ch = c;
		else if (kept_n == 2'd1)
			next_ch = (gap_n != 2'd0) ? CH_SP : c;
		n = kept_n + gap_n + 1;
		kept_n = (n > 3) ? 2'd3 : n[1:0];
		gap_n = 2'd0;
		tail_ch = c;
	endtask

	task automatic take_ch(logic [7:0] b);
		if (cont_left != 2'd0) begin
			cont_left--;
			if (cont_left == 2'd0 && !blank_ch(b))
				cont_open = 1'b0;
			keep_ch(CH_AT);
			return;
		end
		if (blank_ch(b)) begin
			if (kept_n == 2'd0)
				return;
			if (gap_n < 2'd3)
				gap_n++;
			if (head_ch == CH_HASH)
				match_word(b);
			return;
		end
		cont_open = 1'b0;
		if (b[7]) begin
			if ((b & 8'hE0) == 8'hC0) begin
				cont_left = 2'd1;
			end else if ((b & 8'hF0) == 8'hE0) begin
				cont_left = 2'd2;
			end else if ((b & 8'hF8) == 8'hF0) begin
				cont_left = 2'd3;
			end else begin
				bad_utf8 = 1'b1;
				txt_mode = MODE_DONE;
				return;
			end
			cont_open = 1'b1;
			keep_ch(CH_AT);
			return;
		end
		keep_ch(b);
	endtask

	task automatic end_line();
		mode_t nxt;
		nxt = txt_mode;
		if (cont_left != 2'd0 || cont_open) begin
			bad_utf8 = 1'b1;
			nxt = MODE_DONE;
		end else if (txt_mode == MODE_COMMENT) begin
			if (close_st == CLOSE_AT_END)
				nxt = MODE_SCAN;
			else if (close_st == CLOSE_BAD)
				nxt = MODE_DONE;
		end else if (kept_n == 2'd0) begin
			nxt = MODE_SCAN;
		end else if (kept_n == 2'd1 || tail_ch == CH_BSL) begin
			nxt = MODE_DONE;
		end else if (head_ch == CH_SLASH && next_ch == CH_SLASH) begin
			nxt = MODE_SCAN;
		end else if (head_ch == CH_SLASH && next_ch == CH_STAR) begin
			if (close_st == CLOSE_AT_END)
				nxt = MODE_SCAN;
			else if (close_st == CLOSE_BAD)
				nxt = MODE_DONE;
			else
				nxt = MODE_COMMENT;
		end else if (head_ch == CH_HASH && word_pos == WORD_DONE) begin
			incl_line = (line_no < LINE_MAX) ? line_no + 16'd1 : LINE_MAX;
			nxt = MODE_SCAN;
		end else begin
			nxt = MODE_DONE;
		end
		txt_mode = nxt;
		if (line_no < LINE_MAX)
			line_no++;
		clear_line_state();
	endtask

	task automatic scan_beat(logic [7:0] b, logic eot);
		verdict_t v;
		if (txt_mode != MODE_DONE) begin
			if (b == CH_NL)
				end_line();
			else
				take_ch(b);
		end
		if (!eot)
			return;
		if (txt_mode != MODE_DONE && b != CH_NL)
			end_line();
		v.lines = bad_utf8 ? 16'd0 : incl_line;
		v.err = bad_utf8;
		verdict_q.push_back(v);
		restart_text();
	endtask

	// text generation
	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			txt_buf.push_back(s[i]);
	endtask

	task automatic put_blanks(int max_n);
		logic [7:0] pick[5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
		repeat ($urandom_range(max_n, 0))
			txt_buf.push_back(pick[$urandom_range(4, 0)]);
	endtask

	task automatic put_span();
		int n;
		n = $urandom_range(3, 1);
		case (n)
		1: txt_buf.push_back(8'hC0 | 8'($urandom_range(31, 0)));
		2: txt_buf.push_back(8'hE0 | 8'($urandom_range(15, 0)));
		default: txt_buf.push_back(8'hF0 | 8'($urandom_range(7, 0)));
		endcase
		repeat (n)
			txt_buf.push_back(8'h80 | 8'($urandom_range(63, 0)));
	endtask

	task automatic put_junk(int max_n);
		logic [7:0] c;
		repeat ($urandom_range(max_n, 0)) begin
			case ($urandom_range(7, 0))
			0: put_span();
			1: txt_buf.push_back(CH_SP);
			default: begin
				c = 8'($urandom_range(126, 33));
				txt_buf.push_back((c == CH_STAR || c == CH_BSL) ? 8'h61 : c);
			end
			endcase
		end
	endtask

	task automatic put_good_line();
		case ($urandom_range(4, 0))
		0: put_blanks(3);
		1: begin
			put_blanks(2);
			put_str("//");
			put_junk(5);
		end
		2: begin
			put_blanks(2);
			put_str("/*");
			put_junk(4);
			put_str("*/");
			put_blanks(2);
		end
		3: begin
			put_blanks(1);
			put_str("/*");
			put_junk(3);
			repeat ($urandom_range(2, 0)) begin
				txt_buf.push_back(CH_NL);
				put_junk(4);
			end
			put_str("*/");
			put_blanks(1);
		end
		default: begin
			put_blanks(2);
			put_str("#");
			put_blanks(2);
			put_str("include");
			put_blanks(2);
			put_str("<");
			put_junk(3);
			put_str(">");
		end
		endcase
		txt_buf.push_back(CH_NL);
	endtask

	task automatic put_bad_line();
		case ($urandom_range(7, 0))
		0: begin
			put_blanks(1);
			put_str("int x;");
		end
		1: begin
			put_blanks(2);
			txt_buf.push_back(8'($urandom_range(126, 33)));
			put_blanks(2);
		end
		2: put_str("#include a\\");
		3: begin
			if ($urandom_range(1, 0))
				put_str("#inclde x");
			else
				put_str("#define X 1");
		end
		4: begin
			put_str("//");
			if ($urandom_range(1, 0))
				txt_buf.push_back(8'h80 | 8'($urandom_range(63, 0)));
			else
				txt_buf.push_back(8'hF8 | 8'($urandom_range(7, 0)));
		end
		5: begin
			put_str("//");
			txt_buf.push_back(8'hE0 | 8'($urandom_range(15, 0)));
			if ($urandom_range(1, 0))
				txt_buf.push_back(8'h80 | 8'($urandom_range(63, 0)));
		end
		6: begin
			put_str("/*");
			put_junk(2);
			put_str("*/ x");
		end
		default: begin
			repeat ($urandom_range(6, 1))
				txt_buf.push_back(8'($urandom_range(255, 0)));
		end
		endcase
		txt_buf.push_back(CH_NL);
	endtask

	task automatic send_text();
		if (txt_buf.size() == 0)
			txt_buf.push_back(CH_NL);
		foreach (txt_buf[i])
			text_q.push_back('{ch: txt_buf[i], eot: (i == txt_buf.size() - 1)});
		beats_made += txt_buf.size();
		txt_buf.delete();
	endtask

	task automatic queue_text();
		if ($urandom_range(9, 0) == 0) begin
			repeat ($urandom_range(12, 1))
				txt_buf.push_back(8'($urandom_range(255, 0)));
		end else begin
			repeat ($urandom_range(4, 0))
				put_good_line();
			if ($urandom_range(2, 0) != 0) begin
				put_bad_line();
				if ($urandom_range(1, 0))
					put_good_line();
			end
		end
		if (txt_buf.size() > 1 && $urandom_range(1, 0))
			void'(txt_buf.pop_back());
		send_text();
	endtask

	task automatic fill_random(int n);
		int goal;
		goal = beats_made + n;
		while (beats_made < goal)
			queue_text();
	endtask

	task automatic drain();
		while (text_q.size() != 0 || src_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// source driver: predict on every accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin : drive
		beat_t b;
		if (!arst_n) begin
			src_valid <= 1'b0;
			char_byte <= 8'd0;
			end_of_text <= 1'b0;
		end else begin
			if (src_valid && !src_stall)
				scan_beat(char_byte, end_of_text);
			if (!src_valid || !src_stall) begin
				if (text_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
					b = text_q.pop_front();
					src_valid <= 1'b1;
					char_byte <= b.ch;
					end_of_text <= b.eot;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result lines %0d error %0b", $time,
						preamble_lines, utf8_error);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					if (preamble_lines !== want.lines) begin
						$display("%0t: preamble_lines expected %0d, got %0d", $time,
							want.lines, preamble_lines);
						mismatches++;
					end
					if (utf8_error !== want.err) begin
						$display("%0t: utf8_error expected %0b, got %0b", $time,
							want.err, utf8_error);
						mismatches++;
					end
				end
			end
			res_stall <= hold_on || ($urandom_range(99, 0) < res_stall_pct);
		end
	end

	initial begin
		restart_text();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed texts
		put_str("\n");
		send_text();
		put_str("#  include a\n//c\n/*\nx*/\n#include b\nx\n#include c");
		send_text();
		put_str("#include a\\\n");
		send_text();
		put_str("// ");
		txt_buf.push_back(8'hE2);
		txt_buf.push_back(8'h82);
		txt_buf.push_back(8'hAC);
		txt_buf.push_back(CH_NL);
		txt_buf.push_back(8'hFF);
		send_text();
		put_str("// ");
		txt_buf.push_back(8'hE2);
		txt_buf.push_back(8'h82);
		txt_buf.push_back(CH_NL);
		send_text();
		put_str("/* open\n#include");
		send_text();
		put_str("#include\t<a>\n#include");
		send_text();
		put_str("x");
		txt_buf.push_back(8'h00);
		send_text();

		fill_random(240);
		drain();

		src_idle_pct = 81;
		fill_random(240);
		drain();

		src_idle_pct = 0;
		res_stall_pct = 81;
		fill_random(240);
		drain();

		src_idle_pct = 20;
		res_stall_pct = 20;
		fill_random(240);
		drain();

		// hold off results long enough to back the block up to its input
		src_idle_pct = 0;
		res_stall_pct = 0;
		repeat (50) begin
			txt_buf.push_back(8'($urandom_range(255, 0)));
			if ($urandom_range(1, 0))
				put_str("#include a");
			send_text();
		end
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (300) @(posedge clk);
		hold_on <= 1'b0;
		drain();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
